// ----- hw/rtl/ssh_pkg.sv -----
// Shared constants, types and helper functions for the 256-bit sequence state hash.
// No dependencies; imported by ssh_lane_unit, sequence_state_hash_256 and the testbench.
package ssh_pkg;

   localparam int LANE_COUNT = 8;
   localparam int LANE_IDX_W = 3;
   localparam int WORD_W     = 32;
   localparam int ROT_W      = 5;

   localparam logic [WORD_W-1:0] CARRY_SEED = 32'h9e37_79b9;
   localparam logic [WORD_W-1:0] MIX_STEP   = 32'h7f4a_7c15;
   localparam logic [ROT_W-1:0]  CARRY_ROT  = 5'd7;

   localparam logic [0:0] CMD_RESTART = 1'b0;
   localparam logic [0:0] CMD_ABSORB  = 1'b1;

   // Initial vector, lane 0 first
   localparam logic [WORD_W-1:0] INIT_VECTOR [LANE_COUNT] = '{
      32'h243f_6a88, 32'h85a3_08d3, 32'h1319_8a2e, 32'h0370_7344,
      32'ha409_3822, 32'h299f_31d0, 32'h082e_fa98, 32'hec4e_6c89
   };

   // Control for one lane step of the shared unit
   typedef struct packed {
      logic [LANE_IDX_W-1:0] lane_idx;
      logic [ROT_W-1:0]      rot_amt;
   } step_ctl_type;

   // Rotate left by 0..31
   function automatic logic [WORD_W-1:0] rot_left(input logic [WORD_W-1:0] v,
                                                  input logic [ROT_W-1:0]  s);
      logic [2*WORD_W-1:0] t;
      t = {v, v} << s;
      return t[2*WORD_W-1:WORD_W];
   endfunction

   // Per-lane mix offset: MIX_STEP * (lane + 1), modulo 2^32 (constant table)
   function automatic logic [WORD_W-1:0] mix_offset(input logic [LANE_IDX_W-1:0] idx);
      logic [WORD_W-1:0] k;
      k = {{(WORD_W-LANE_IDX_W){1'b0}}, idx} + 32'd1;
      return MIX_STEP * k;
   endfunction

endpackage

// ----- hw/rtl/ssh_lane_unit.sv -----
// Shared lane update datapath: one lane and the carry word per use.
// Depends on ssh_pkg (rot_left, mix_offset, step_ctl_type).
module ssh_lane_unit
   import ssh_pkg::*;
(
   input  step_ctl_type      ctl,
   input  logic [WORD_W-1:0] lane_val,
   input  logic [WORD_W-1:0] follow_val,
   input  logic [WORD_W-1:0] carry_val,
   output logic [WORD_W-1:0] lane_new,
   output logic [WORD_W-1:0] carry_new
);

   logic [WORD_W-1:0] mix;
   logic [WORD_W-1:0] rotated;

   // Mix, rotate, then add the following lane
   always_comb begin
      mix       = carry_val + mix_offset(ctl.lane_idx);
      rotated   = rot_left(lane_val ^ mix, ctl.rot_amt);
      lane_new  = rotated + follow_val;
      carry_new = lane_new ^ rot_left(carry_val, CARRY_ROT);
   end

endmodule

// ----- hw/rtl/sequence_state_hash_256.sv -----
// Top level of the 256-bit sequence state hash: lane store, sequencer, output register.
// Depends on ssh_pkg and ssh_lane_unit.
//
// Usage:
//   Input channel req_*: req_cmd selects restart (0) or absorb (1); req_symbol is the
//   32-bit symbol. A transaction is taken when req_valid is high and req_stall low.
//   Result channel rsp_*: rsp_word0..rsp_word7 carry all eight lanes after the item;
//   a transaction completes when rsp_valid is high and rsp_stall low.
//   Sequencing: an absorb walks the eight lanes through one shared lane unit, one
//   lane per cycle, then hands the lanes to the output register; a restart loads
//   the initial vector and goes straight to the hand-off step. No new item is
//   taken until the hand-off is done.
//   The output register parts the channels: a new item is taken while a result
//   waits; when the receiver stalls, the finished item holds in its last step until
//   the output register frees.
//   Reset (synchronous, active high) loads the initial vector and empties the
//   output register.
module sequence_state_hash_256
   import ssh_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [0:0]        req_cmd,
   input  logic [WORD_W-1:0] req_symbol,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [WORD_W-1:0] rsp_word0,
   output logic [WORD_W-1:0] rsp_word1,
   output logic [WORD_W-1:0] rsp_word2,
   output logic [WORD_W-1:0] rsp_word3,
   output logic [WORD_W-1:0] rsp_word4,
   output logic [WORD_W-1:0] rsp_word5,
   output logic [WORD_W-1:0] rsp_word6,
   output logic [WORD_W-1:0] rsp_word7
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [LANE_IDX_W-1:0] idx_ff, idx_in;
   logic [WORD_W-1:0]     carry_ff, carry_in;
   logic [ROT_W-1:0]      sym_ff, sym_in;
   logic [WORD_W-1:0]     lanes_ff [LANE_COUNT];
   logic [WORD_W-1:0]     lanes_in [LANE_COUNT];
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]     out_ff [LANE_COUNT];
   logic                  out_load;

   step_ctl_type      ctl;
   logic [WORD_W-1:0] lane_new;
   logic [WORD_W-1:0] carry_new;
   logic              req_take;
   logic              out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Rotation amount (5*lane + symbol) mod 32, 5-bit wrap
   assign ctl.lane_idx = idx_ff;
   assign ctl.rot_amt  = {idx_ff, 2'b00} + {2'b00, idx_ff} + sym_ff;

   // Lane under work sits at position 0, its follower at position 1
   ssh_lane_unit u_lane (
      .ctl        (ctl),
      .lane_val   (lanes_ff[0]),
      .follow_val (lanes_ff[1]),
      .carry_val  (carry_ff),
      .lane_new   (lane_new),
      .carry_new  (carry_new)
   );

   // Sequencer: accept, walk eight lanes (absorb only), hand off to output register
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      carry_in     = carry_ff;
      sym_in       = sym_ff;
      lanes_in     = lanes_ff;
      out_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_cmd == CMD_ABSORB) begin
                  idx_in   = '0;
                  carry_in = req_symbol ^ CARRY_SEED;
                  sym_in   = req_symbol[ROT_W-1:0];
                  state_in = ST_RUN;
               end else begin
                  lanes_in = INIT_VECTOR;
                  state_in = ST_WAIT;
               end
            end
         end
         ST_RUN: begin
            // Shift lanes down, append the updated lane; eight steps restore order
            for (int k = 0; k < LANE_COUNT - 1; k++) begin
               lanes_in[k] = lanes_ff[k+1];
            end
            lanes_in[LANE_COUNT-1] = lane_new;
            carry_in = carry_new;
            idx_in   = idx_ff + 1'b1;
            if (idx_ff == LANE_IDX_W'(LANE_COUNT - 1)) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (out_free) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and lane state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         lanes_ff     <= INIT_VECTOR;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         lanes_ff     <= lanes_in;
      end
   end

   // Working payload, no reset needed
   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
      sym_ff   <= sym_in;
      if (out_load) begin
         out_ff <= lanes_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word0 = out_ff[0];
   assign rsp_word1 = out_ff[1];
   assign rsp_word2 = out_ff[2];
   assign rsp_word3 = out_ff[3];
   assign rsp_word4 = out_ff[4];
   assign rsp_word5 = out_ff[5];
   assign rsp_word6 = out_ff[6];
   assign rsp_word7 = out_ff[7];

   // Checks on the sequencer
   a_run_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && idx_ff != LANE_IDX_W'(LANE_COUNT - 1))
         |=> (state_ff == ST_RUN && idx_ff == $past(idx_ff) + 1'b1))
      else $error("lane index did not advance during absorb");

   a_rsp_from_wait: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_WAIT)
      else $error("result raised outside hand-off step");

   a_wait_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT && rsp_valid_ff && rsp_stall) |=> state_ff == ST_WAIT)
      else $error("finished item overwrote a stalled result");

   a_restart_direct: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_cmd == CMD_RESTART) |=> state_ff == ST_WAIT)
      else $error("restart did not go straight to hand-off");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for sequence_state_hash_256: random and directed restart/absorb traffic.
// Depends on ssh_pkg and the sequence_state_hash_256 RTL; lane prediction is computed locally.
`timescale 1ns / 100ps

module testbench;
   import ssh_pkg::*;

   typedef logic [LANE_COUNT-1:0][WORD_W-1:0] lane_vec_type;

   typedef struct {
      logic [0:0]        cmd;
      logic [WORD_W-1:0] symbol;
      int unsigned       gap;
   } hash_req_type;

   localparam int unsigned RANDOM_ITEMS = 2000;
   localparam int unsigned HOLD_CYCLES  = 250;
   localparam int unsigned PRINT_CAP    = 40;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_valid  = 1'b0;
   logic [0:0]        req_cmd    = CMD_RESTART;
   logic [WORD_W-1:0] req_symbol = '0;
   logic              rsp_stall  = 1'b0;
   logic              req_stall;
   logic              rsp_valid;
   logic [WORD_W-1:0] rsp_word0, rsp_word1, rsp_word2, rsp_word3;
   logic [WORD_W-1:0] rsp_word4, rsp_word5, rsp_word6, rsp_word7;

   hash_req_type pending_q[$];
   lane_vec_type expected_lanes_q[$];
   lane_vec_type lane_state;
   int unsigned drv_waited  = 0;
   int unsigned rcv_wait    = 0;
   int unsigned hold_left   = 0;
   int unsigned hold_mark   = 400;
   int unsigned n_restart   = 0;
   int unsigned n_absorb    = 0;
   int unsigned n_checked   = 0;
   int unsigned n_mismatch  = 0;
   int unsigned n_holds     = 0;

   sequence_state_hash_256 dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_cmd    (req_cmd),
      .req_symbol (req_symbol),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word0  (rsp_word0),
      .rsp_word1  (rsp_word1),
      .rsp_word2  (rsp_word2),
      .rsp_word3  (rsp_word3),
      .rsp_word4  (rsp_word4),
      .rsp_word5  (rsp_word5),
      .rsp_word6  (rsp_word6),
      .rsp_word7  (rsp_word7)
   );

   always #4 clock = ~clock;

   // Rotate a word left; a zero amount passes the word through
   function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                                input int unsigned n);
      int unsigned s;
      s = n % 32;
      if (s == 0) return v;
      return (v << s) | (v >> (32 - s));
   endfunction

   // Compute the lanes after one restart or absorb transaction
   function automatic lane_vec_type next_lanes(input lane_vec_type cur,
                                               input logic [0:0] cmd,
                                               input logic [WORD_W-1:0] sym);
      lane_vec_type      nxt;
      logic [WORD_W-1:0] carry;
      logic [WORD_W-1:0] follow;
      logic [WORD_W-1:0] mix;
      int unsigned       amt;
      if (cmd == CMD_RESTART) begin
         for (int i = 0; i < LANE_COUNT; i++) nxt[i] = INIT_VECTOR[i];
         return nxt;
      end
      nxt   = cur;
      carry = sym ^ CARRY_SEED;
      for (int i = 0; i < LANE_COUNT; i++) begin
         // lane 7 picks up lane 0 as already updated
         follow = nxt[(i + 1) % LANE_COUNT];
         mix    = carry + MIX_STEP * 32'(i + 1);
         amt    = (5 * i + sym[4:0]) % 32;
         nxt[i] = rotl32(nxt[i] ^ mix, amt) + follow;
         carry  = nxt[i] ^ rotl32(carry, CARRY_ROT);
      end
      return nxt;
   endfunction

   task automatic report_mismatch(input string msg);
      if (n_mismatch < PRINT_CAP) $display("%0t ERROR: %s", $time, msg);
      n_mismatch++;
   endtask

   // Idle gap before an item: runs of none, runs of random, runs of rare gaps
   function automatic int unsigned draw_gap(input int unsigned idx);
      case ((idx / 120) % 3)
         0: return 0;
         1: return $urandom_range(0, 16);
         default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
      endcase
   endfunction

   task automatic queue_item(input logic [0:0] cmd, input logic [WORD_W-1:0] sym);
      hash_req_type it;
      it.cmd    = cmd;
      it.symbol = sym;
      it.gap    = draw_gap(pending_q.size() + n_restart + n_absorb);
      pending_q.push_back(it);
   endtask

   // Driver: present queued transactions, predict lanes on accept
   always @(posedge clock) begin
      logic         nxt_valid;
      hash_req_type it;
      nxt_valid = req_valid;
      if (reset) begin
         nxt_valid = 1'b0;
         for (int i = 0; i < LANE_COUNT; i++) lane_state[i] = INIT_VECTOR[i];
      end else begin
         if (req_valid && !req_stall) begin
            lane_state = next_lanes(lane_state, req_cmd, req_symbol);
            expected_lanes_q.push_back(lane_state);
            if (req_cmd == CMD_RESTART) n_restart++;
            else n_absorb++;
            nxt_valid = 1'b0;
         end
         if (!nxt_valid && pending_q.size() > 0) begin
            if (drv_waited < pending_q[0].gap) begin
               drv_waited++;
            end else begin
               it         = pending_q.pop_front();
               req_cmd    <= it.cmd;
               req_symbol <= it.symbol;
               nxt_valid  = 1'b1;
               drv_waited = 0;
            end
         end
      end
      req_valid <= nxt_valid;
   end

   // Long receiver hold-off so the block backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (n_checked >= hold_mark) begin
         hold_left <= HOLD_CYCLES;
         hold_mark <= hold_mark + 1100;
         n_holds   <= n_holds + 1;
      end
   end

   // Monitor: take results, compare lane by lane, draw the next stall
   always @(posedge clock) begin
      lane_vec_type got;
      lane_vec_type want;
      if (reset) begin
         rcv_wait  = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_word7, rsp_word6, rsp_word5, rsp_word4,
                   rsp_word3, rsp_word2, rsp_word1, rsp_word0};
            if (expected_lanes_q.size() == 0) begin
               report_mismatch("result transaction with no expectation pending");
            end else begin
               want = expected_lanes_q.pop_front();
               for (int i = 0; i < LANE_COUNT; i++)
                  if (got[i] !== want[i])
                     report_mismatch($sformatf("result %0d word%0d: got %08h expected %08h",
                                               n_checked, i, got[i], want[i]));
            end
            n_checked++;
            case ((n_checked / 100) % 3)
               0: rcv_wait = $urandom_range(0, 16);
               1: rcv_wait = 0;
               default: rcv_wait = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
            endcase
         end
         rsp_stall <= (hold_left != 0) || (rcv_wait > 0);
         if (rcv_wait > 0) rcv_wait--;
      end
   end

   // Stimulus and end of run
   initial begin
      logic [WORD_W-1:0] sym;
      // directed: restart with symbol ignored, field extremes, zero rotations
      queue_item(CMD_RESTART, 32'hffff_ffff);
      queue_item(CMD_ABSORB,  32'h0000_0000);
      queue_item(CMD_ABSORB,  32'hffff_ffff);
      queue_item(CMD_ABSORB,  32'h8000_0000);
      queue_item(CMD_ABSORB,  32'h0000_0001);
      queue_item(CMD_ABSORB,  32'haaaa_aaaa);
      queue_item(CMD_ABSORB,  32'h5555_5555);
      queue_item(CMD_ABSORB,  32'h0000_001f);
      queue_item(CMD_RESTART, 32'h0000_0000);
      // each lane i sees a zero rotation when symbol[4:0] = (32 - 5*i) mod 32
      for (int i = 0; i < LANE_COUNT; i++)
         queue_item(CMD_ABSORB, {27'($urandom_range(0, 32'h07ff_ffff)),
                                 5'((32 - 5 * i) % 32)});
      queue_item(CMD_RESTART, 32'h1234_5678);
      queue_item(CMD_ABSORB,  32'hffff_ffe0);
      queue_item(CMD_ABSORB,  32'h7fff_ffff);
      // random: long absorb runs with occasional restarts
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         sym = $urandom();
         if ($urandom_range(0, 15) == 0) queue_item(CMD_RESTART, sym);
         else queue_item(CMD_ABSORB, sym);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // wait for all transactions accepted, then drained
      while (pending_q.size() > 0 || req_valid) @(posedge clock);
      while (expected_lanes_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (expected_lanes_q.size() > 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   expected_lanes_q.size()));
      $display("Run covered %0d absorb and %0d restart transactions, %0d results checked,",
               n_absorb, n_restart, n_checked);
      $display("with %0d long receiver hold-offs and %0d mismatches.", n_holds, n_mismatch);
      if (n_mismatch == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5ms;
      $display("Timeout with %0d results still pending", expected_lanes_q.size());
      $display("Verification failed");
      $finish;
   end

endmodule
